// File: design/topk_smallest_selector_assert.svh
// ----------------------------------------------------------------------------
// topk_smallest_selector assertion macros
// Immediate-consequence and next-cycle property macros on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef TOPK_SMALLEST_SELECTOR_ASSERT_SVH
`define TOPK_SMALLEST_SELECTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TOPK_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("topk_smallest_selector: property violated");

// Consequent must hold in the cycle after the antecedent.
`define TOPK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("topk_smallest_selector: property violated");

`endif

// File: design/topk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topk_pkg
// Shared types and constants of the top-k smallest-distance selector.
// ----------------------------------------------------------------------------
package topk_pkg;

    localparam int KEEP_W = 5;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [31:0] distance;
        logic        [31:0] row_id;
    } topk_req_t;

    typedef struct packed {
        logic        [31:0] out_row_id;
        logic signed [31:0] out_distance;
        logic               is_last;
        logic               none_held;
    } topk_res_t;

    // One heap slot.
    typedef struct packed {
        logic signed [31:0] key;
        logic        [31:0] row;
    } topk_entry_t;

endpackage

// File: design/topk_heap_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topk_heap_mem
// Heap slot storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module topk_heap_mem
    import topk_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  topk_entry_t   wr_data,
    input  logic [AW-1:0] rd_addr,
    output topk_entry_t   rd_data
);

    topk_entry_t slots [DEPTH];
    topk_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= slots[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/topk_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topk_cmp
// Shared signed Q16.16 key comparator: flags lhs strictly greater than rhs.
// ----------------------------------------------------------------------------
module topk_cmp
    import topk_pkg::*;
(
    input  logic signed [31:0] lhs,
    input  logic signed [31:0] rhs,
    output logic               gt
);

    assign gt = (lhs > rhs);

endmodule

// File: design/topk_smallest_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topk_smallest_selector
// Keeps the keep_count smallest-distance candidates in a binary max-heap and
// drains them in ascending distance order.
// ----------------------------------------------------------------------------
// An insert request (command 0) appends and sifts up, reading and comparing
// one parent per level while the heap is filling, or checks the root and
// sifts down, reading up to two children per level visited, when it
// replaces the root of a full heap. A drain request (command 1) holding n
// entries runs n selection passes over the heap slots, one slot read per
// cycle through the single read port of the slot memory, with output stalls
// between passes; an empty drain gives one result flagged none_held.
// Drain results come out in ascending distance, ties in heap slot order,
// with is_last on the final one. Both sift and selection share one signed
// comparator, and the sequencer takes no new request until the current one
// is done; the result register lets the next request enter while the final
// result still waits. keep_count is 0..31 and saturates to 1..MAX_KEEP;
// write it only while the block is idle.
// ----------------------------------------------------------------------------
module topk_smallest_selector
    import topk_pkg::*;
#(
    parameter int MAX_KEEP = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [KEEP_W-1:0] cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  topk_req_t         in_req,
    output logic              out_valid,
    input  logic              out_ready,
    output topk_res_t         out_res
);

    localparam int AW  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CW  = $clog2(MAX_KEEP + 1);
    localparam int CHW = CW + 1;
    localparam int EW  = ((CW > KEEP_W) ? CW : KEEP_W) + 1;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_ROOT_CMP = 10'b00_0000_0010,
        ST_UP       = 10'b00_0000_0100,
        ST_UP_CMP   = 10'b00_0000_1000,
        ST_DN_L     = 10'b00_0001_0000,
        ST_DN_LC    = 10'b00_0010_0000,
        ST_DN_RC    = 10'b00_0100_0000,
        ST_SCAN     = 10'b00_1000_0000,
        ST_EMIT     = 10'b01_0000_0000,
        ST_EMPTY    = 10'b10_0000_0000
    } topk_state_t;

    topk_state_t       state_reg, state_next;
    logic [KEEP_W-1:0] keep_reg;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [AW-1:0]     j_reg, j_next;
    topk_entry_t       carry_reg, carry_next;
    topk_entry_t       best_reg, best_next;
    logic [AW-1:0]     best_idx_reg, best_idx_next;
    logic              have_best_reg, have_best_next;
    logic [CW-1:0]     scan_idx_reg, scan_idx_next;
    logic              pend_vld_reg, pend_vld_next;
    logic [AW-1:0]     pend_idx_reg, pend_idx_next;
    logic [CW-1:0]     drain_n_reg, drain_n_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [MAX_KEEP-1:0] mask_reg, mask_next;
    logic              out_valid_reg, out_valid_next;
    topk_res_t         out_res_reg, out_res_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    topk_entry_t       mem_wdata;
    logic [AW-1:0]     mem_raddr;
    topk_entry_t       rd_entry;

    logic signed [31:0] cmp_lhs;
    logic signed [31:0] cmp_rhs;
    logic               cmp_gt;

    logic [AW-1:0]  j_parent;
    logic [CHW-1:0] left_w;
    logic [CHW-1:0] right_w;
    logic [CHW-1:0] fill_w;
    logic           has_room;
    logic           out_free;
    logic           scan_take;

    topk_heap_mem #(
        .DEPTH (MAX_KEEP),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (rd_entry)
    );

    topk_cmp u_cmp (
        .lhs (cmp_lhs),
        .rhs (cmp_rhs),
        .gt  (cmp_gt)
    );

    // Heap geometry around the current hole.
    assign j_parent = (j_reg - AW'(1)) >> 1;
    assign left_w   = (CHW'(j_reg) << 1) + CHW'(1);
    assign right_w  = (CHW'(j_reg) << 1) + CHW'(2);
    assign fill_w   = CHW'(fill_reg);

    // Room to append: below saturated keep_count and below capacity.
    assign has_room = (fill_reg < CW'(MAX_KEEP)) &&
                      ((EW'(fill_reg) < EW'(keep_reg)) ||
                       ((keep_reg == '0) && (fill_reg == '0)));

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // Selection pass keeps the first strictly smaller unemitted slot.
    assign scan_take = pend_vld_reg && !mask_reg[pend_idx_reg] &&
                       (!have_best_reg || cmp_gt);

    // Comparator operand steering.
    always_comb
    begin
        cmp_lhs = rd_entry.key;
        cmp_rhs = carry_reg.key;
        case (state_reg)
            ST_UP_CMP:
            begin
                cmp_lhs = carry_reg.key;
                cmp_rhs = rd_entry.key;
            end
            ST_DN_RC:
            begin
                cmp_lhs = rd_entry.key;
                cmp_rhs = best_reg.key;
            end
            ST_SCAN:
            begin
                cmp_lhs = best_reg.key;
                cmp_rhs = rd_entry.key;
            end
            default:
            begin
                cmp_lhs = rd_entry.key;
                cmp_rhs = carry_reg.key;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        j_next         = j_reg;
        carry_next     = carry_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        have_best_next = have_best_reg;
        scan_idx_next  = scan_idx_reg;
        pend_vld_next  = pend_vld_reg;
        pend_idx_next  = pend_idx_reg;
        drain_n_next   = drain_n_reg;
        rem_next       = rem_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_res_next   = out_res_reg;
        mem_we         = 1'b0;
        mem_waddr      = j_reg;
        mem_wdata      = carry_reg;
        mem_raddr      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                // Keep the root on the read port for a replace decision.
                mem_raddr = '0;
                if (in_valid)
                begin
                    carry_next.key = in_req.distance;
                    carry_next.row = in_req.row_id;
                    if (in_req.command == CMD_DRAIN)
                    begin
                        drain_n_next   = fill_reg;
                        rem_next       = fill_reg;
                        fill_next      = '0;
                        mask_next      = '0;
                        scan_idx_next  = '0;
                        pend_vld_next  = 1'b0;
                        have_best_next = 1'b0;
                        state_next     = (fill_reg == '0) ? ST_EMPTY : ST_SCAN;
                    end
                    else if (has_room)
                    begin
                        j_next     = AW'(fill_reg);
                        fill_next  = fill_reg + CW'(1);
                        state_next = ST_UP;
                    end
                    else
                    begin
                        state_next = ST_ROOT_CMP;
                    end
                end
            end

            ST_ROOT_CMP:
            begin
                // Replace the root only when the new key is strictly smaller.
                if (cmp_gt)
                begin
                    j_next     = '0;
                    state_next = ST_DN_L;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_UP:
            begin
                if (j_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_raddr  = j_parent;
                    state_next = ST_UP_CMP;
                end
            end

            ST_UP_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_gt)
                begin
                    // Pull the parent down into the hole and climb.
                    mem_wdata  = rd_entry;
                    j_next     = j_parent;
                    state_next = ST_UP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_DN_L:
            begin
                if (left_w < fill_w)
                begin
                    mem_raddr  = AW'(left_w);
                    state_next = ST_DN_LC;
                end
                else
                begin
                    mem_we     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_DN_LC:
            begin
                best_next     = cmp_gt ? rd_entry : carry_reg;
                best_idx_next = cmp_gt ? AW'(left_w) : j_reg;
                if (right_w < fill_w)
                begin
                    mem_raddr  = AW'(right_w);
                    state_next = ST_DN_RC;
                end
                else
                begin
                    mem_we = 1'b1;
                    if (cmp_gt)
                    begin
                        mem_wdata  = rd_entry;
                        j_next     = AW'(left_w);
                        state_next = ST_DN_L;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_DN_RC:
            begin
                mem_we = 1'b1;
                if (cmp_gt)
                begin
                    mem_wdata  = rd_entry;
                    j_next     = AW'(right_w);
                    state_next = ST_DN_L;
                end
                else if (best_idx_reg != j_reg)
                begin
                    mem_wdata  = best_reg;
                    j_next     = best_idx_reg;
                    state_next = ST_DN_L;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                // Issue one slot read per cycle and compare its registered data in the next cycle.
                if (scan_idx_reg < drain_n_reg)
                begin
                    mem_raddr     = AW'(scan_idx_reg);
                    pend_vld_next = 1'b1;
                    pend_idx_next = AW'(scan_idx_reg);
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                else
                begin
                    pend_vld_next = 1'b0;
                end
                if (scan_take)
                begin
                    best_next      = rd_entry;
                    best_idx_next  = pend_idx_reg;
                    have_best_next = 1'b1;
                end
                if ((scan_idx_reg == drain_n_reg) && !pend_vld_reg)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_res_next.out_row_id   = best_reg.row;
                    out_res_next.out_distance = best_reg.key;
                    out_res_next.is_last      = (rem_reg == CW'(1));
                    out_res_next.none_held    = 1'b0;
                    mask_next[best_idx_reg]   = 1'b1;
                    rem_next                  = rem_reg - CW'(1);
                    scan_idx_next             = '0;
                    have_best_next            = 1'b0;
                    state_next = (rem_reg == CW'(1)) ? ST_IDLE : ST_SCAN;
                end
            end

            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_res_next.out_row_id   = '0;
                    out_res_next.out_distance = '0;
                    out_res_next.is_last      = 1'b1;
                    out_res_next.none_held    = 1'b1;
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            keep_reg      <= KEEP_RESET;
            fill_reg      <= '0;
            j_reg         <= '0;
            best_idx_reg  <= '0;
            have_best_reg <= 1'b0;
            scan_idx_reg  <= '0;
            pend_vld_reg  <= 1'b0;
            pend_idx_reg  <= '0;
            drain_n_reg   <= '0;
            rem_reg       <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wr_en)
            begin
                keep_reg <= cfg_wr_data;
            end
            fill_reg      <= fill_next;
            j_reg         <= j_next;
            best_idx_reg  <= best_idx_next;
            have_best_reg <= have_best_next;
            scan_idx_reg  <= scan_idx_next;
            pend_vld_reg  <= pend_vld_next;
            pend_idx_reg  <= pend_idx_next;
            drain_n_reg   <= drain_n_next;
            rem_reg       <= rem_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        carry_reg   <= carry_next;
        best_reg    <= best_next;
        out_res_reg <= out_res_next;
    end

endmodule

// File: design/topk_smallest_selector_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topk_smallest_selector_chk
// Port-level checks of the selector, bound onto the top level.
// ----------------------------------------------------------------------------
`include "topk_smallest_selector_assert.svh"

module topk_smallest_selector_chk
    import topk_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cfg_wr_en,
    input logic [KEEP_W-1:0] cfg_wr_data,
    input logic              in_valid,
    input logic              in_ready,
    input topk_req_t         in_req,
    input logic              out_valid,
    input logic              out_ready,
    input topk_res_t         out_res
);

    // Hold a stalled result.
    `TOPK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_res))

    // An empty drain is a single, final result.
    `TOPK_ASSERT_SAME(a_empty_last, out_valid && out_res.none_held, out_res.is_last)

    // An empty drain carries zero payload.
    `TOPK_ASSERT_SAME(a_empty_zero, out_valid && out_res.none_held, (out_res.out_row_id == 32'd0) && (out_res.out_distance == 32'sd0))

    // Every accepted request takes the sequencer out of idle, so in_ready drops.
    `TOPK_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)

endmodule

bind topk_smallest_selector topk_smallest_selector_chk u_chk (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the top-k smallest-distance selector. A shadow heap
// tracks every accepted request and queues the entries that each drain must
// emit; every result leaving the block is compared field by field against
// the oldest queued entry. Directed tests cover empty drains, field extremes,
// root replacement, keep_count saturation and lowering keep_count below the
// fill level; random phases then run insert bursts closed by drains under
// varying idle patterns, plus one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import topk_pkg::*;

    localparam int          MAX_KEEP        = 16;
    localparam int          CLK_PERIOD      = 20;
    localparam int          RESET_CYCLES    = 10;
    // Wait well past the longest insert before a keep_count write so the
    // sequencer is surely idle.
    localparam int          CFG_SETTLE      = 40;
    localparam int          END_SETTLE      = 400;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int unsigned TIMEOUT_CYCLES  = 1_000_000;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [KEEP_W-1:0] cfg_wr_data = '0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    topk_req_t         in_req      = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    topk_res_t         out_res;

    // Idle probabilities in percent per cycle, set per phase by the tests.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Hold-off handshake between the test sequence and the receiver: the
    // sequence bumps hold_off_asked, the receiver notices and counts down.
    int hold_off_asked = 0;
    int hold_off_seen  = 0;
    int hold_off_left  = 0;

    // Shadow of the block: heap slots, fill level and keep_count register.
    logic signed [31:0] kept_dist [MAX_KEEP];
    logic        [31:0] kept_row  [MAX_KEEP];
    int unsigned        kept_fill    = 0;
    logic [KEEP_W-1:0]  keep_setting = KEEP_RESET;

    // Entries that accepted drain requests still have to emit, oldest first.
    topk_res_t pending_emits [$];
    int        mismatch_count = 0;

    topk_smallest_selector #(
        .MAX_KEEP (MAX_KEEP)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_req      (in_req),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_res     (out_res)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow heap
    // ------------------------------------------------------------------------

    // Saturate the register: 0 acts as 1, anything above MAX_KEEP as MAX_KEEP.
    function automatic int unsigned keep_limit();
        if (keep_setting == 0)
        begin
            return 1;
        end
        if (keep_setting > MAX_KEEP)
        begin
            return MAX_KEEP;
        end
        return keep_setting;
    endfunction

    function automatic void swap_kept(input int unsigned a, input int unsigned b);
        logic signed [31:0] d;
        logic        [31:0] r;
        d            = kept_dist[a];
        r            = kept_row[a];
        kept_dist[a] = kept_dist[b];
        kept_row[a]  = kept_row[b];
        kept_dist[b] = d;
        kept_row[b]  = r;
    endfunction

    // Apply one accepted request to the shadow heap; a drain queues the
    // entries it must emit in ascending distance, ties in slot order.
    function automatic void track_heap(input topk_req_t req);
        logic signed [31:0] dist_in;
        logic signed [31:0] sd [MAX_KEEP];
        logic        [31:0] sr [MAX_KEEP];
        logic signed [31:0] key;
        logic        [31:0] row;
        topk_res_t          res;
        int unsigned        j, p, l, r, best, n, i;
        dist_in = req.distance;
        if (req.command == CMD_INSERT)
        begin
            if (kept_fill < keep_limit() && kept_fill < MAX_KEEP)
            begin
                // Append and sift up; swap only when the parent is strictly smaller.
                j = kept_fill;
                kept_fill++;
                kept_dist[j] = dist_in;
                kept_row[j]  = req.row_id;
                while (j > 0)
                begin
                    p = (j - 1) / 2;
                    if (kept_dist[p] >= kept_dist[j])
                    begin
                        break;
                    end
                    swap_kept(p, j);
                    j = p;
                end
            end
            else if (kept_fill > 0 && dist_in < kept_dist[0])
            begin
                // Replace the root and sift down toward the strictly larger child.
                j            = 0;
                kept_dist[0] = dist_in;
                kept_row[0]  = req.row_id;
                while (1)
                begin
                    l    = 2 * j + 1;
                    r    = 2 * j + 2;
                    best = j;
                    if (l < kept_fill && kept_dist[l] > kept_dist[best])
                    begin
                        best = l;
                    end
                    if (r < kept_fill && kept_dist[r] > kept_dist[best])
                    begin
                        best = r;
                    end
                    if (best == j)
                    begin
                        break;
                    end
                    swap_kept(j, best);
                    j = best;
                end
            end
            return;
        end

        n         = kept_fill;
        kept_fill = 0;
        if (n == 0)
        begin
            res           = '0;
            res.is_last   = 1'b1;
            res.none_held = 1'b1;
            pending_emits.push_back(res);
            return;
        end
        for (i = 0; i < n; i++)
        begin
            key = kept_dist[i];
            row = kept_row[i];
            j   = i;
            while (j > 0 && sd[j-1] > key)
            begin
                sd[j] = sd[j-1];
                sr[j] = sr[j-1];
                j--;
            end
            sd[j] = key;
            sr[j] = row;
        end
        for (i = 0; i < n; i++)
        begin
            res.out_row_id   = sr[i];
            res.out_distance = sd[i];
            res.is_last      = (i + 1 == n);
            res.none_held    = 1'b0;
            pending_emits.push_back(res);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Receiver and result check
    // ------------------------------------------------------------------------

    // Drive out_ready: hold it low for a long stretch when asked, otherwise
    // drop it at random with the current idle probability.
    always @(posedge clk)
    begin
        if (hold_off_seen != hold_off_asked)
        begin
            hold_off_seen = hold_off_asked;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left = hold_off_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic log_mismatch(input string what, input topk_res_t want,
                                input topk_res_t got);
        if (mismatch_count < 10)
        begin
            $display("%0t %s: expected row %08h dist %08h last %0b empty %0b, got row %08h dist %08h last %0b empty %0b",
                     $realtime, what, want.out_row_id, want.out_distance, want.is_last,
                     want.none_held, got.out_row_id, got.out_distance, got.is_last,
                     got.none_held);
        end
        mismatch_count++;
    endtask

    // Compare every accepted result with the oldest pending entry.
    always @(posedge clk)
    begin
        topk_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_emits.size() == 0)
            begin
                log_mismatch("result with nothing pending", '0, out_res);
            end
            else
            begin
                want = pending_emits.pop_front();
                if (out_res.out_row_id !== want.out_row_id ||
                    out_res.out_distance !== want.out_distance ||
                    out_res.is_last !== want.is_last ||
                    out_res.none_held !== want.none_held)
                begin
                    log_mismatch("result mismatch", want, out_res);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offer one request and hold it until accepted. Valid stays high on return
    // so a back-to-back request never lowers and raises it in one step.
    task automatic send_request(input topk_req_t req);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        track_heap(req);
    endtask

    task automatic send_insert(input logic [31:0] dist_val, input logic [31:0] row);
        topk_req_t req;
        req.command  = CMD_INSERT;
        req.distance = dist_val;
        req.row_id   = row;
        send_request(req);
    endtask

    // Drain with random don't-care fields to show they are ignored.
    task automatic send_drain();
        topk_req_t req;
        req.command  = CMD_DRAIN;
        req.distance = $urandom();
        req.row_id   = $urandom();
        send_request(req);
    endtask

    // Write keep_count only once the block is idle: drop valid, wait for all
    // pending results, then let any trailing insert finish.
    task automatic write_keep(input logic [KEEP_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_emits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        keep_setting = value;
    endtask

    // Pick a distance in one of several styles: full range, a narrow band
    // that forces ties, the extremes, or moderate Q16.16 values.
    function automatic logic [31:0] pick_distance(input int style);
        case (style)
            0: return $urandom();
            1: return $urandom_range(0, 6) - 3;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return $urandom();
                endcase
            end
            default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Drain right after reset: one result flagged empty.
    task automatic test_empty_drain();
        send_drain();
    endtask

    // Extremes of distance and row id at the reset keep_count, with a tie.
    task automatic test_field_extremes();
        send_insert(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_insert(32'h8000_0000, 32'h0000_0000);
        send_insert(32'h0000_0000, 32'h0F0F_0F0F);
        send_insert(32'hFFFF_FFFF, 32'hF0F0_F0F0);
        send_insert(32'h0001_0000, 32'h0000_0001);
        send_insert(32'h0001_0000, 32'h0000_0002);
        send_drain();
    endtask

    // Full heap of three: equal and larger distances drop, a smaller one
    // replaces the root.
    task automatic test_root_replace();
        write_keep(5'd3);
        send_insert(32'd5, 32'd10);
        send_insert(32'd5, 32'd11);
        send_insert(32'd9, 32'd12);
        send_insert(32'd9, 32'd13);
        send_insert(32'd12, 32'd14);
        send_insert(32'd2, 32'd15);
        send_drain();
    endtask

    // keep_count of zero acts as one.
    task automatic test_keep_saturation();
        write_keep(5'd0);
        send_insert(32'd7, 32'd20);
        send_insert(32'd3, 32'd21);
        send_insert(32'd3, 32'd22);
        send_drain();
    endtask

    // Lower keep_count below the fill level: no held entry drops, inserts only
    // replace the root, and the drain still emits every held entry.
    task automatic test_keep_lowered();
        write_keep(5'd16);
        send_insert(32'd40, 32'd30);
        send_insert(32'd10, 32'd31);
        send_insert(32'd30, 32'd32);
        send_insert(32'd20, 32'd33);
        write_keep(5'd2);
        send_insert(32'd5, 32'd34);
        send_insert(32'd50, 32'd35);
        send_drain();
        send_drain();
    endtask

    // Hold the receiver off while requests keep coming, so the drain backs
    // up and the input stalls.
    task automatic test_output_backpressure();
        int i;
        write_keep(5'd8);
        hold_off_asked <= hold_off_asked + 1;
        for (i = 0; i < 10; i++)
        begin
            send_insert(pick_distance(0), $urandom());
        end
        send_drain();
        for (i = 0; i < 6; i++)
        begin
            send_insert(pick_distance(1), $urandom());
        end
        send_drain();
    endtask

    // Mostly insert bursts closed by a drain, with lone drains and unclosed
    // bursts mixed in; leftover entries carry into the next phase.
    task automatic test_random_phase(input int item_target, input int snd_pct,
                                     input int rcv_pct, input logic [KEEP_W-1:0] keep_value);
        int sent;
        int burst;
        int kind;
        int style;
        int i;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        write_keep(keep_value);
        sent = 0;
        while (sent < item_target)
        begin
            kind  = $urandom_range(0, 99);
            style = $urandom_range(0, 3);
            if (kind < 85)
            begin
                burst = $urandom_range(0, keep_limit() + 6);
                for (i = 0; i < burst; i++)
                begin
                    send_insert(pick_distance(style), $urandom());
                end
                send_drain();
                sent += burst + 1;
            end
            else if (kind < 93)
            begin
                send_drain();
                sent++;
            end
            else
            begin
                burst = $urandom_range(1, 4);
                for (i = 0; i < burst; i++)
                begin
                    send_insert(pick_distance(style), $urandom());
                end
                sent += burst;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 30;
        recv_idle_pct = 55;
        test_empty_drain();
        test_field_extremes();
        test_root_replace();
        test_keep_saturation();
        test_keep_lowered();

        test_random_phase(50, 30, 55, 5'd16);
        test_random_phase(50, 30, 55, 5'd5);
        test_random_phase(50, 55, 30, 5'd31);
        test_random_phase(50, 55, 30, 5'd1);
        test_output_backpressure();
        test_random_phase(50, 0, 0, 5'd0);
        test_random_phase(50, 0, 0, 5'($urandom_range(2, 15)));

        // Drop valid, wait out every pending result, then let the block settle
        // so any stray result still gets caught.
        in_valid <= 1'b0;
        while (pending_emits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (END_SETTLE) @(posedge clk);
        if (mismatch_count == 0 && pending_emits.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: topk_smallest_selector.f
+incdir+design
design/topk_pkg.sv
design/topk_heap_mem.sv
design/topk_cmp.sv
design/topk_smallest_selector.sv
design/topk_smallest_selector_chk.sv
sim/testbench.sv
